// File: rtl/numerov_wavefunction_integrator_macros.svh
// assertion helpers, clocked on clk, disabled during rst
`ifndef NUMEROV_WAVEFUNCTION_INTEGRATOR_MACROS_SVH
`define NUMEROV_WAVEFUNCTION_INTEGRATOR_MACROS_SVH

`define NWI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("numerov integrator check failed");

`define NWI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("numerov integrator check failed");

`endif

// File: rtl/numwi_pkg.sv
// ----------------------------------------------------------------------------
// numwi_pkg
// shared types and constants of the numerov integrator
// ----------------------------------------------------------------------------
package numwi_pkg;

  localparam int SAMPLE_W = 48;
  localparam int PSI_W    = 64;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_STEADY = 2'd2;

  localparam logic [1:0] CFG_ENERGY    = 2'd0;
  localparam logic [1:0] CFG_STEP_SQ   = 2'd1;
  localparam logic [1:0] CFG_STEP_SQ12 = 2'd2;

  localparam logic [5:0] MUL_LAST = 6'd4;
  localparam logic [5:0] DIV_LAST = 6'd47;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_RND1, OP_RND2, OP_RND3,
    OP_SUM, OP_DIV_INIT, OP_DIV, OP_FIN
  } op_t;

  typedef enum logic [1:0] {SEL_A, SEL_B, SEL_C} mul_sel_t;

  typedef struct packed {
    op_t        op;
    mul_sel_t   sel;
    logic [2:0] cnt;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic last;
  } sts_t;

endpackage

// File: rtl/numwi_ctrl.sv
// ----------------------------------------------------------------------------
// numwi_ctrl
// sequencer: multiplies, rounding, sums, divide and result write-back
// ----------------------------------------------------------------------------
module numwi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output numwi_pkg::cmd_t cmd,
  input  numwi_pkg::sts_t sts
);
  import numwi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_R1, S_M2, S_R2, S_M3, S_R3, S_SUM, S_DI, S_DIV, S_FIN
  } state_t;

  state_t     state;
  logic [5:0] ctr;
  logic [1:0] phase;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.sel   = SEL_A;
    cmd.cnt   = ctr[2:0];
    cmd.phase = phase;
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = OP_LOAD;
      S_M1:   cmd.op = OP_MUL;
      S_R1:   cmd.op = OP_RND1;
      S_M2: begin
        cmd.op  = OP_MUL;
        cmd.sel = SEL_B;
      end
      S_R2:   cmd.op = OP_RND2;
      S_M3: begin
        cmd.op  = OP_MUL;
        cmd.sel = SEL_C;
      end
      S_R3:   cmd.op = OP_RND3;
      S_SUM:  cmd.op = OP_SUM;
      S_DI:   cmd.op = OP_DIV_INIT;
      S_DIV:  cmd.op = OP_DIV;
      S_FIN:  if (!sts.out_busy) cmd.op = OP_FIN;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctr   <= '0;
      phase <= PH_FIRST;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          state <= S_M1;
          ctr   <= '0;
        end
        S_M1, S_M2, S_M3: begin
          if (ctr == MUL_LAST) begin
            ctr <= '0;
            if (state == S_M1) state <= S_R1;
            else if (state == S_M2) state <= S_R2;
            else state <= S_R3;
          end else begin
            ctr <= ctr + 6'd1;
          end
        end
        S_R1: begin
          if (phase == PH_FIRST || phase == PH_SECOND) state <= S_FIN;
          else state <= S_M2;
        end
        S_R2:  state <= S_M3;
        S_R3:  state <= S_SUM;
        S_SUM: state <= S_DI;
        S_DI: begin
          state <= S_DIV;
          ctr   <= '0;
        end
        S_DIV: begin
          if (ctr == DIV_LAST) state <= S_FIN;
          else ctr <= ctr + 6'd1;
        end
        S_FIN: if (!sts.out_busy) begin
          state <= S_IDLE;
          if (sts.last) phase <= PH_FIRST;
          else if (phase == PH_FIRST) phase <= PH_SECOND;
          else phase <= PH_STEADY;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/numwi_dp.sv
// ----------------------------------------------------------------------------
// numwi_dp
// fixed-point datapath: config, recurrence state, multiplier, divider, output
// ----------------------------------------------------------------------------
module numwi_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  numwi_pkg::cmd_t                 cmd,
  output numwi_pkg::sts_t                 sts,
  input  logic [numwi_pkg::SAMPLE_W-1:0]  potential_sample,
  input  logic                            last_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [numwi_pkg::PSI_W-1:0]     psi_value,
  output logic                            end_of_run,
  output logic                            overflow,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [numwi_pkg::SAMPLE_W-1:0]  cfg_data
);
  import numwi_pkg::*;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE  = 64'h0000_0001_0000_0000;

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? 64'd0 - v : v;
  endfunction

  function automatic logic [64:0] rnd(input logic [127:0] a, input logic s48,
                                      input logic neg);
    logic [127:0] sum;
    logic [63:0]  m;
    logic         big;
    sum = a + (s48 ? {80'd0, 1'b1, 47'd0} : {96'd0, 1'b1, 31'd0});
    m   = s48 ? sum[111:48] : sum[95:32];
    big = s48 ? (|sum[127:112]) : (|sum[127:96]);
    if (neg) begin
      if (big || m > SMIN) rnd = {1'b1, SMIN};
      else rnd = {1'b0, 64'd0 - m};
    end else begin
      if (big || m > SMAX) rnd = {1'b1, SMAX};
      else rnd = {1'b0, m};
    end
  endfunction

  function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b,
                                       input logic sub);
    logic [63:0] r;
    logic        ovf;
    r   = sub ? a - b : a + b;
    ovf = sub ? (a[63] != b[63] && r[63] != a[63]) : (a[63] == b[63] && r[63] != a[63]);
    if (ovf) sadd = {1'b1, a[63] ? SMIN : SMAX};
    else sadd = {1'b0, r};
  endfunction

  function automatic logic [128:0] dstep(input logic [63:0] rm, input logic [63:0] qu,
                                         input logic bg, input logic nb,
                                         input logic [63:0] dm);
    logic [63:0] r;
    logic [63:0] qq;
    logic        b;
    r  = {rm[62:0], nb};
    b  = bg | qu[63];
    qq = {qu[62:0], 1'b0};
    if (rm[63] || r >= dm) begin
      r     = r - dm;
      qq[0] = 1'b1;
    end
    dstep = {b, r, qq};
  endfunction

  logic [47:0]  trial_energy;
  logic [47:0]  step_sq;
  logic [47:0]  step_sq12;
  logic [63:0]  f, nf, older_aux, newer_aux, prev_psi, d, t, u, q;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [63:0]  nsh, dmag, rem, quo;
  logic         big, ov, last;

  logic [48:0]  dv;
  logic [63:0]  ma, mb;
  logic [31:0]  aw, bw;
  logic [63:0]  prod;
  logic [2:0]   km1;
  logic [6:0]   sh;
  logic [127:0] shifted;
  logic         rnd_neg;
  logic [64:0]  rr;
  logic [64:0]  s1, s2, s3;
  logic [128:0] st1, st2;
  logic [63:0]  dres, psi_fin;
  logic         dov, ov_fin;

  assign cfg_ready    = 1'b1;
  assign sts.out_busy = out_valid & out_stall;
  assign sts.last     = last;

  assign dv = {potential_sample[47], potential_sample} - {trial_energy[47], trial_energy};

  always_comb begin
    unique case (cmd.sel)
      SEL_A: begin
        ma = mag(f);
        mb = {16'd0, step_sq12};
      end
      SEL_B: begin
        ma = mag(nf);
        mb = {16'd0, step_sq};
      end
      SEL_C: begin
        ma = mag(t);
        mb = mag(prev_psi);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    aw      = cmd.cnt[1] ? ma[63:32] : ma[31:0];
    bw      = cmd.cnt[0] ? mb[63:32] : mb[31:0];
    prod    = {32'd0, aw} * {32'd0, bw};
    km1     = cmd.cnt - 3'd1;
    sh      = ({6'd0, km1[1]} + {6'd0, km1[0]}) << 5;
    shifted = {64'd0, pp} << sh;
  end

  always_comb begin
    unique case (cmd.op)
      OP_RND1: rnd_neg = f[63];
      OP_RND2: rnd_neg = nf[63];
      default: rnd_neg = t[63] ^ prev_psi[63];
    endcase
    rr  = rnd(acc, cmd.op != OP_RND3, rnd_neg);
    s1  = sadd(newer_aux, newer_aux, 1'b0);
    s2  = sadd(s1[63:0], older_aux, 1'b1);
    s3  = sadd(s2[63:0], u, 1'b0);
    st1 = dstep(rem, quo, big, nsh[63], dmag);
    st2 = dstep(st1[127:64], st1[63:0], st1[128], nsh[62], dmag);
  end

  always_comb begin
    dov = 1'b0;
    if (d == 64'd0) begin
      dov  = 1'b1;
      dres = q[63] ? SMIN : SMAX;
    end else if (q[63] ^ d[63]) begin
      if (big || quo > SMIN) begin
        dov  = 1'b1;
        dres = SMIN;
      end else begin
        dres = 64'd0 - quo;
      end
    end else begin
      if (big || quo > SMAX) begin
        dov  = 1'b1;
        dres = SMAX;
      end else begin
        dres = quo;
      end
    end
    unique case (cmd.phase)
      PH_FIRST: begin
        psi_fin = '0;
        ov_fin  = ov;
      end
      PH_SECOND: begin
        psi_fin = ONE;
        ov_fin  = ov;
      end
      default: begin
        psi_fin = dres;
        ov_fin  = ov | dov;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trial_energy <= '0;
      step_sq      <= 48'd11261251;
      step_sq12    <= 48'd938437;
      older_aux    <= '0;
      newer_aux    <= '0;
      nf           <= '0;
      prev_psi     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ENERGY:    trial_energy <= cfg_data;
          CFG_STEP_SQ:   step_sq      <= cfg_data;
          CFG_STEP_SQ12: step_sq12    <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && cmd.op != OP_FIN) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          f    <= {{14{dv[48]}}, dv, 1'b0};
          last <= last_sample;
          ov   <= 1'b0;
        end
        OP_MUL: begin
          if ({3'd0, cmd.cnt} != MUL_LAST) pp <= prod;
          if (cmd.cnt == 3'd0) acc <= '0;
          else acc <= acc + shifted;
        end
        OP_RND1: begin
          d  <= ONE - rr[63:0];
          ov <= ov | rr[64];
        end
        OP_RND2: begin
          t  <= rr[63:0];
          ov <= ov | rr[64];
        end
        OP_RND3: begin
          u  <= rr[63:0];
          ov <= ov | rr[64];
        end
        OP_SUM: begin
          q  <= s3[63:0];
          ov <= ov | s1[64] | s2[64] | s3[64];
        end
        OP_DIV_INIT: begin
          nsh  <= mag(q);
          dmag <= mag(d);
          rem  <= '0;
          quo  <= '0;
          big  <= 1'b0;
        end
        OP_DIV: begin
          big <= st2[128];
          rem <= st2[127:64];
          quo <= st2[63:0];
          nsh <= nsh << 2;
        end
        OP_FIN: begin
          psi_value  <= psi_fin;
          end_of_run <= last;
          overflow   <= ov_fin;
          out_valid  <= 1'b1;
          if (last) begin
            older_aux <= '0;
            newer_aux <= '0;
            nf        <= '0;
            prev_psi  <= '0;
          end else begin
            nf       <= f;
            prev_psi <= psi_fin;
            unique case (cmd.phase)
              PH_FIRST: begin
                older_aux <= '0;
                newer_aux <= '0;
              end
              PH_SECOND: begin
                older_aux <= '0;
                newer_aux <= d;
              end
              default: begin
                older_aux <= newer_aux;
                newer_aux <= q;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/numerov_wavefunction_integrator.sv
// ----------------------------------------------------------------------------
// numerov_wavefunction_integrator
// streams potential samples and returns one numerov wavefunction sample each
// ----------------------------------------------------------------------------
// One request is in flight at a time. The first two points of a run need one
// 64x64 product; in steady state a sample needs three 64x64 products, each
// built from four 32x32 partial products on one shared multiplier, and a
// 96-step restoring divider that retires two quotient bits per cycle. The
// finished result sits in an output register, so a new sample is taken while
// it waits to be collected.
`include "numerov_wavefunction_integrator_macros.svh"

module numerov_wavefunction_integrator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] potential_sample,
  input  logic        last_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] psi_value,
  output logic        end_of_run,
  output logic        overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import numwi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  numwi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  numwi_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .potential_sample (potential_sample),
    .last_sample      (last_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .psi_value        (psi_value),
    .end_of_run       (end_of_run),
    .overflow         (overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  `NWI_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
  `NWI_ASSERT_NEXT(a_result_posted, cmd.op == OP_FIN, out_valid)
  `NWI_ASSERT_IMPL(a_no_overwrite, cmd.op == OP_FIN, !(out_valid && out_stall))

endmodule

// File: sim/tb_numerov_wavefunction_integrator.sv
// ----------------------------------------------------------------------------
// tb_numerov_wavefunction_integrator
// streams potential samples through the integrator and checks every psi
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a driver on the falling edge. A monitor
// on the rising edge captures results and compares them with psi values
// predicted by a fixed-point model of the recurrence. Register writes happen
// only between phases, with nothing in flight.
module tb_numerov_wavefunction_integrator;
  import numwi_pkg::*;

  localparam logic [63:0] SAT_HI = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_LO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_Q  = 64'h1_0000_0000;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [47:0] pot;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [63:0] psi;
    logic        eor;
    logic        ovf;
  } psi_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [47:0] potential_sample = '0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] psi_value;
  logic end_of_run;
  logic overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;

  sample_t  pending_q[$];
  psi_res_t psi_expected_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  idling_on = 1'b1;
  bit  hold_out = 1'b0;
  bit  in_acc = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  // predictor state
  logic [47:0] energy_r, hsq_r, hsq12_r;
  logic [63:0] aux_old, aux_new, force_prev, psi_prev;
  logic [1:0]  phase_r;

  numerov_wavefunction_integrator i_dut (.*);

  always #6 clk = ~clk;

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // signed times signed/unsigned, magnitude rounded half away, saturated
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, bit b_signed,
                                         int s, inout bit ov);
    logic [127:0] p;
    logic [127:0] r;
    bit neg;
    neg = a[63] ^ (b_signed & b[63]);
    p = {64'd0, mag(a)} * {64'd0, (b_signed ? mag(b) : b)};
    r = (p + (128'd1 << (s - 1))) >> s;
    if (neg) begin
      if (r > {64'd0, SAT_LO}) begin ov = 1; return SAT_LO; end
      return -r[63:0];
    end
    if (r > {64'd0, SAT_HI}) begin ov = 1; return SAT_HI; end
    return r[63:0];
  endfunction

  function automatic logic [63:0] fx_add(logic [63:0] a, logic [63:0] b, inout bit ov);
    logic [64:0] r;
    r = {a[63], a} + {b[63], b};
    if (r[64] != r[63]) begin ov = 1; return r[64] ? SAT_LO : SAT_HI; end
    return r[63:0];
  endfunction

  function automatic logic [63:0] fx_sub(logic [63:0] a, logic [63:0] b, inout bit ov);
    logic [64:0] r;
    r = {a[63], a} - {b[63], b};
    if (r[64] != r[63]) begin ov = 1; return r[64] ? SAT_LO : SAT_HI; end
    return r[63:0];
  endfunction

  function automatic logic [63:0] fx_div(logic [63:0] q, logic [63:0] d, inout bit ov);
    logic [127:0] n, quo;
    bit neg;
    if (d == 0) begin ov = 1; return q[63] ? SAT_LO : SAT_HI; end
    neg = q[63] ^ d[63];
    n = {64'd0, mag(q)} << 32;
    quo = n / {64'd0, mag(d)};
    if (neg) begin
      if (quo > {64'd0, SAT_LO}) begin ov = 1; return SAT_LO; end
      return -quo[63:0];
    end
    if (quo > {64'd0, SAT_HI}) begin ov = 1; return SAT_HI; end
    return quo[63:0];
  endfunction

  function automatic psi_res_t integrate_sample(sample_t s);
    logic [63:0] f, d, t, u, q, psi;
    bit ov;
    psi_res_t r;
    ov = 0;
    f = ({{16{s.pot[47]}}, s.pot} - {{16{energy_r[47]}}, energy_r}) << 1;
    d = ONE_Q - fx_mul(f, {16'd0, hsq12_r}, 0, 48, ov);
    if (phase_r == PH_FIRST) begin
      psi = 0; aux_old = 0; aux_new = 0; phase_r = PH_SECOND;
    end else if (phase_r == PH_SECOND) begin
      psi = ONE_Q; aux_old = 0; aux_new = d; phase_r = PH_STEADY;
    end else begin
      t = fx_mul(force_prev, {16'd0, hsq_r}, 0, 48, ov);
      u = fx_mul(t, psi_prev, 1, 32, ov);
      q = fx_add(aux_new, aux_new, ov);
      q = fx_sub(q, aux_old, ov);
      q = fx_add(q, u, ov);
      psi = fx_div(q, d, ov);
      aux_old = aux_new; aux_new = q; phase_r = PH_STEADY;
    end
    force_prev = f;
    psi_prev = psi;
    if (s.last) begin
      phase_r = PH_FIRST;
      aux_old = 0; aux_new = 0; force_prev = 0; psi_prev = 0;
    end
    r.psi = psi; r.eor = s.last; r.ovf = ov;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc || !in_valid) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (idling_on && in_valid && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(1, 10) - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid <= 1'b1;
          potential_sample <= pending_q[0].pot;
          last_sample <= pending_q[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_out) out_stall <= 1'b1;
      else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      in_acc = in_valid && !in_stall;
      if (in_acc) begin
        psi_expected_q.push_back(integrate_sample(pending_q.pop_front()));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (psi_expected_q.size() == 0) begin
          report_mismatch("unexpected result", psi_value, '0);
        end else begin
          psi_res_t w;
          w = psi_expected_q.pop_front();
          if (psi_value !== w.psi) report_mismatch("psi_value", psi_value, w.psi);
          if (end_of_run !== w.eor)
            report_mismatch("end_of_run", {63'd0, end_of_run}, {63'd0, w.eor});
          if (overflow !== w.ovf)
            report_mismatch("overflow", {63'd0, overflow}, {63'd0, w.ovf});
        end
      end
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || psi_expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_ENERGY) energy_r = val;
    else if (idx == CFG_STEP_SQ) hsq_r = val;
    else if (idx == CFG_STEP_SQ12) hsq12_r = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [47:0] rand_pot();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return r[47:0];
      1: return 48'h7FFF_FFFF_FFFF;
      2: return 48'h8000_0000_0000;
      default: return {14'd0, r[33:0]} - (48'd2 << 32);
    endcase
  endfunction

  task automatic queue_runs(int n);
    int len;
    while (n > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      for (int k = 0; k < len && n > 0; k++, n--) begin
        sample_t s;
        s.pot = rand_pot();
        s.last = (k == len - 1) || ($urandom_range(0, 60) == 0);
        pending_q.push_back(s);
      end
    end
  endtask

  initial begin
    sample_t s;
    energy_r = '0; hsq_r = 48'd11261251; hsq12_r = 48'd938437;
    aux_old = 0; aux_new = 0; force_prev = 0; psi_prev = 0; phase_r = PH_FIRST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: linear ramp, extremes, single and two-sample runs
    for (int k = 0; k < 12; k++) begin
      s.pot = 48'(k - 6) << 30; s.last = (k == 11); pending_q.push_back(s);
    end
    s.pot = 48'h7FFF_FFFF_FFFF; s.last = 1; pending_q.push_back(s);
    s.pot = 48'h8000_0000_0000; s.last = 0; pending_q.push_back(s);
    s.last = 1; pending_q.push_back(s);
    for (int k = 0; k < 5; k++) begin
      s.pot = k[0] ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      s.last = (k == 4); pending_q.push_back(s);
    end
    wait_drained();

    // zero divisor: h^2/12 * 2(V-E) == 1.0 with h^2/12 = 2^-4, V-E = 8
    write_reg(CFG_STEP_SQ12, 48'h1000_0000_0000);
    write_reg(CFG_ENERGY, '0);
    for (int k = 0; k < 5; k++) begin
      s.pot = 48'd8 << 32; s.last = (k == 4); pending_q.push_back(s);
    end
    wait_drained();

    // long receiver hold-off while requests keep coming
    hold_out = 1'b1;
    queue_runs(30);
    repeat (800) @(posedge clk);
    hold_out = 1'b0;
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_ENERGY, 48'h7FFF_FFFF_FFFF);
                 write_reg(CFG_STEP_SQ, 48'hFFFF_FFFF_FFFF);
                 write_reg(CFG_STEP_SQ12, 48'hFFFF_FFFF_FFFF); end
        1: begin write_reg(CFG_ENERGY, 48'h8000_0000_0000);
                 write_reg(CFG_STEP_SQ, '0); write_reg(CFG_STEP_SQ12, '0); end
        2: begin write_reg(CFG_ENERGY, rand48());
                 write_reg(CFG_STEP_SQ, rand48());
                 write_reg(CFG_STEP_SQ12, rand48()); end
        default: begin write_reg(CFG_ENERGY, 48'd1 << 32);
                 write_reg(CFG_STEP_SQ, 48'd11261251);
                 write_reg(CFG_STEP_SQ12, 48'd938437); end
      endcase
      if (ph == 4) idling_on = 1'b0;
      queue_runs(ph == 4 ? 200 : 250);
      wait_drained();
    end

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/numwi_pkg.sv
rtl/numwi_ctrl.sv
rtl/numwi_dp.sv
rtl/numerov_wavefunction_integrator.sv
sim/tb_numerov_wavefunction_integrator.sv
